FILE: rtl/core/u16550_pkg.sv
// shared types, codes and a helper function for the 16550 register core
package u16550_pkg;

   typedef struct packed {
      logic [1:0] req_type;
      logic [5:0] reg_offset;
      logic [7:0] write_data;
      logic       rx_line;
   } req_item_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       tx_line;
      logic       irq;
   } rsp_item_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic clear;
   } fifo_ctl_type;

   // transaction kinds
   localparam logic [1:0] REQ_READ  = 2'd0;
   localparam logic [1:0] REQ_WRITE = 2'd1;
   localparam logic [1:0] REQ_TICK  = 2'd2;

   // register word indexes
   localparam logic [5:0] REG_RBR = 6'd0;
   localparam logic [5:0] REG_IER = 6'd1;
   localparam logic [5:0] REG_IIR = 6'd2;
   localparam logic [5:0] REG_LCR = 6'd3;
   localparam logic [5:0] REG_MCR = 6'd4;
   localparam logic [5:0] REG_LSR = 6'd5;
   localparam logic [5:0] REG_SCR = 6'd7;

   // interrupt identification codes
   localparam logic [3:0] IIR_NONE = 4'h1;
   localparam logic [3:0] IIR_THRE = 4'h2;
   localparam logic [3:0] IIR_RDA  = 4'h4;
   localparam logic [3:0] IIR_RLS  = 4'h6;
   localparam logic [3:0] IIR_CTO  = 4'hC;

   // parity bit for a masked data word under the given line control
   function automatic logic parity_bit(input logic [7:0] lcr, input logic [7:0] data);
      logic x;
      x = ^data;
      if (lcr[5]) return ~lcr[4];
      return lcr[4] ? x : ~x;
   endfunction

endpackage

FILE: rtl/core/u16550_ram.sv
// generic single-write, single-read ram with registered read data
module u16550_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read-first: a read of the address being written returns the old data
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/u16550_fifo.sv
// circular fifo with head register and look-ahead of the following entry
module u16550_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  u16550_pkg::fifo_ctl_type  ctl,
   input  logic [WIDTH-1:0]          wr_data,
   output logic [CW-1:0]             count,
   output logic [CW-1:0]             count_next,
   output logic [WIDTH-1:0]          head,
   output logic [WIDTH-1:0]          nxt
);
   import u16550_pkg::*;

   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
   localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);

   logic [AW-1:0]    head_ptr_ff, head_ptr_in;
   logic [AW-1:0]    wr_addr, rd_addr;
   logic [AW:0]      tail_sum;
   logic [CW-1:0]    count_ff, count_in;
   logic [WIDTH-1:0] head_ff, head_in;
   logic [WIDTH-1:0] ram_data;
   logic [WIDTH-1:0] byp_data_ff;
   logic             byp_valid_ff, byp_valid_in;

   function automatic logic [AW-1:0] step_ptr(input logic [AW-1:0] p);
      return (p == LAST) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      tail_sum = {1'b0, head_ptr_ff} + (AW + 1)'(count_ff);
      if (tail_sum >= DEPTH_W) begin
         wr_addr = AW'(tail_sum - DEPTH_W);
      end else begin
         wr_addr = tail_sum[AW-1:0];
      end
   end

   always_comb begin
      count_in    = count_ff;
      head_ptr_in = head_ptr_ff;
      head_in     = head_ff;
      priority if (ctl.clear) begin
         count_in = '0;
      end else if (ctl.push) begin
         count_in = count_ff + 1'b1;
         if (count_ff == '0) begin
            head_in = wr_data;
         end
      end else if (ctl.pop) begin
         count_in    = count_ff - 1'b1;
         head_ptr_in = step_ptr(head_ptr_ff);
         head_in     = nxt;
      end
   end

   // keep the entry behind the head read ahead
   assign rd_addr      = step_ptr(head_ptr_in);
   assign byp_valid_in = ctl.push && (wr_addr == rd_addr);
   assign nxt          = byp_valid_ff ? byp_data_ff : ram_data;

   u16550_ram #(
      .WIDTH (WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ctl.push),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (ram_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ptr_ff  <= '0;
         count_ff     <= '0;
         byp_valid_ff <= 1'b0;
      end else begin
         head_ptr_ff  <= head_ptr_in;
         count_ff     <= count_in;
         byp_valid_ff <= byp_valid_in;
      end
      head_ff     <= head_in;
      byp_data_ff <= wr_data;
   end

   assign count      = count_ff;
   assign count_next = count_in;
   assign head       = head_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("fifo count beyond depth");

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      ctl.push |-> (count_ff < CW'(DEPTH)) && !ctl.pop)
      else $error("fifo push while full or together with pop");

endmodule

FILE: rtl/core/u16550_skid.sv
// two-entry output buffer between the core and the result channel
module u16550_skid (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_stall,
   input  u16550_pkg::rsp_item_type  in_data,
   output logic                      out_valid,
   input  logic                      out_stall,
   output u16550_pkg::rsp_item_type  out_data
);
   import u16550_pkg::*;

   rsp_item_type main_data_ff, main_data_in, skid_data_ff, skid_data_in;
   logic         main_valid_ff, main_valid_in, skid_valid_ff, skid_valid_in;
   logic         take, load;

   assign take = main_valid_ff && !out_stall;
   assign load = in_valid && !skid_valid_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (take) begin
         if (skid_valid_ff) begin
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = load;
            main_data_in  = in_data;
         end
      end else if (load) begin
         if (main_valid_ff) begin
            skid_valid_in = 1'b1;
            skid_data_in  = in_data;
         end else begin
            main_valid_in = 1'b1;
            main_data_in  = in_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign in_stall  = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry held without a main entry");

endmodule

FILE: rtl/core/uart_16550_register_core.sv
// top level of the 16550-compatible uart register core
//
// usage:
//   req channel (req_valid / req_stall / req_data) carries one transaction per
//   accepted cycle: a bus read, a bus write, or one reference clock tick that
//   samples the receive line. registers sit on a 4-byte stride (word index).
//   rsp channel (rsp_valid / rsp_stall / rsp_data) returns exactly one result
//   per request transaction: read data, the transmit line level and irq.
// result: each result is registered in the output buffer and driven onto rsp from there.
// throughput: one transaction per cycle while req_stall is low; all register, fifo and
//   shift engine updates are done in one pass between the request channel and the
//   result registers. the fifos hold their entries in ram with a registered read, and
//   the entry behind each head is read ahead so a pop is done in the same pass.
// stall: a two-entry output buffer keeps req_stall low while one result waits;
//   req_stall rises only when both entries are held by a stalled receiver.
// reset: synchronous, active high. registers clear, both fifos empty,
//   transmitter idle with the line high, receiver waiting for a start bit.
//   no clearing pass is needed; the core takes requests right after reset.
module uart_16550_register_core #(
   parameter int FIFO_DEPTH = 64,
   parameter int OVERSAMPLE = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  u16550_pkg::req_item_type  req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output u16550_pkg::rsp_item_type  rsp_data
);
   import u16550_pkg::*;

   localparam int CW = $clog2(FIFO_DEPTH + 1);
   localparam int SW = $clog2(OVERSAMPLE + 1);
   localparam int TRIG_QTR  = (FIFO_DEPTH / 4 < 1) ? 1 : FIFO_DEPTH / 4;
   localparam int TRIG_HALF = (FIFO_DEPTH / 2 < 1) ? 1 : FIFO_DEPTH / 2;
   localparam int TRIG_HIGH = (FIFO_DEPTH > 2) ? FIFO_DEPTH - 2 : 1;
   localparam int TMO_SCALE = 4 * OVERSAMPLE;

   typedef enum logic [3:0] {
      RX_IDLE  = 4'b0001,
      RX_START = 4'b0010,
      RX_DATA  = 4'b0100,
      RX_BREAK = 4'b1000
   } rx_state_type;

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   logic [7:0]   lcr_ff, lcr_in;
   logic [15:0]  div_ff, div_in;
   logic [3:0]   ier_ff, ier_in;
   logic [7:0]   fcr_ff, fcr_in;
   logic [4:0]   mcr_ff, mcr_in;
   logic [7:0]   scr_ff, scr_in;
   logic [15:0]  baud_ff, baud_in;
   // transmit engine
   logic         tx_busy_ff, tx_busy_in;
   logic [12:0]  tx_shift_ff, tx_shift_in;
   logic [3:0]   tx_left_ff, tx_left_in;
   logic [SW-1:0] tx_sub_ff, tx_sub_in;
   // receive engine
   rx_state_type rx_state_ff, rx_state_in;
   logic [SW-1:0] rx_sub_ff, rx_sub_in;
   logic [3:0]   rx_got_ff, rx_got_in;
   logic [9:0]   rx_shift_ff, rx_shift_in;
   // lsr bits 4:1, transmitter empty pending, idle time, entries with errors
   logic [3:0]   lsf_ff, lsf_in;
   logic         thre_ff, thre_in;
   logic [15:0]  rx_idle_ff, rx_idle_in;
   logic [CW-1:0] rx_err_cnt_ff, rx_err_cnt_in;

   // ---------------------------------------------------------------------
   // fifo hookup
   // ---------------------------------------------------------------------
   fifo_ctl_type tx_ctl, rx_ctl;
   logic [7:0]   tx_wdata, tx_head, tx_nxt;
   logic [10:0]  rx_wdata, rx_head, rx_nxt;
   logic [CW-1:0] tx_count, tx_count_next, rx_count, rx_count_next;

   // ---------------------------------------------------------------------
   // working values
   // ---------------------------------------------------------------------
   logic         accept;
   logic         dlab;
   logic [3:0]   wl;
   logic [7:0]   wmask;
   logic [CW-1:0] depth_now;
   logic [7:0]   rd;
   logic [3:0]   iir_cur, iir_next;
   logic [7:0]   lsr_cur;
   logic         tx_bit_cur;
   logic [7:0]   fcr_new;
   logic         rx_clear, tx_clear;
   logic [15:0]  baud_inc;
   logic         rin;
   logic [SW-1:0] tx_sub_inc, rx_sub_inc;
   logic [7:0]   tx_word;
   logic [3:0]   tx_pos;
   logic [3:0]   rx_got_inc;
   logic [9:0]   rx_shift_t;
   logic [7:0]   rx_word;
   logic         rx_pe, rx_fe, rx_bi;
   logic         rx_pushed;
   logic [15:0]  idle_base;
   rsp_item_type rsp_in;

   function automatic logic [CW-1:0] rx_trigger(input logic [7:0] fcr);
      if (!fcr[0]) return CW'(1);
      unique case (fcr[7:6])
         2'd0:    return CW'(1);
         2'd1:    return CW'(TRIG_QTR);
         2'd2:    return CW'(TRIG_HALF);
         default: return CW'(TRIG_HIGH);
      endcase
   endfunction

   // character timeout: four frame times of oversampled pulses
   function automatic logic timeout(input logic [7:0] fcr, input logic [7:0] lcr,
                                    input logic [CW-1:0] cnt, input logic [15:0] idle);
      logic [3:0]  frame;
      logic [15:0] thr;
      frame = 4'd6 + {2'b0, lcr[1:0]} + {3'b0, lcr[3]} + (lcr[2] ? 4'd2 : 4'd1);
      thr   = 16'(frame) * 16'(TMO_SCALE);
      return fcr[0] && (cnt != '0) && (idle >= thr);
   endfunction

   function automatic logic [3:0] iir_code(input logic [3:0] ier, input logic [3:0] lsf,
                                           input logic at_trig, input logic tmo,
                                           input logic thre);
      priority if (ier[2] && (lsf != '0)) return IIR_RLS;
      else if (ier[0] && at_trig) return IIR_RDA;
      else if (ier[0] && tmo) return IIR_CTO;
      else if (ier[1] && thre) return IIR_THRE;
      else return IIR_NONE;
   endfunction

   assign accept     = req_valid && !req_stall;
   assign dlab       = lcr_ff[7];
   assign wl         = 4'd5 + {2'b0, lcr_ff[1:0]};
   assign wmask      = 8'hFF >> (2'd3 - lcr_ff[1:0]);
   assign depth_now  = fcr_ff[0] ? CW'(FIFO_DEPTH) : CW'(1);
   assign tx_bit_cur = lcr_ff[6] ? 1'b0 : (tx_busy_ff ? tx_shift_ff[0] : 1'b1);

   assign iir_cur = iir_code(ier_ff, lsf_ff, rx_count >= rx_trigger(fcr_ff),
                             timeout(fcr_ff, lcr_ff, rx_count, rx_idle_ff), thre_ff);
   assign lsr_cur = {fcr_ff[0] && (rx_err_cnt_ff != '0),
                     (tx_count == '0) && !tx_busy_ff,
                     tx_count == '0,
                     lsf_ff,
                     rx_count != '0};

   // ---------------------------------------------------------------------
   // one pass over the accepted transaction
   // ---------------------------------------------------------------------
   always_comb begin
      lcr_in        = lcr_ff;
      div_in        = div_ff;
      ier_in        = ier_ff;
      fcr_in        = fcr_ff;
      mcr_in        = mcr_ff;
      scr_in        = scr_ff;
      baud_in       = baud_ff;
      tx_busy_in    = tx_busy_ff;
      tx_shift_in   = tx_shift_ff;
      tx_left_in    = tx_left_ff;
      tx_sub_in     = tx_sub_ff;
      rx_state_in   = rx_state_ff;
      rx_sub_in     = rx_sub_ff;
      rx_got_in     = rx_got_ff;
      rx_shift_in   = rx_shift_ff;
      lsf_in        = lsf_ff;
      thre_in       = thre_ff;
      rx_idle_in    = rx_idle_ff;
      rx_err_cnt_in = rx_err_cnt_ff;
      tx_ctl        = '0;
      rx_ctl        = '0;
      tx_wdata      = req_data.write_data;
      rx_wdata      = '0;
      rd            = '0;
      fcr_new       = '0;
      rx_clear      = 1'b0;
      tx_clear      = 1'b0;
      baud_inc      = baud_ff + 16'd1;
      rin           = mcr_ff[4] ? tx_bit_cur : req_data.rx_line;
      tx_sub_inc    = tx_sub_ff + 1'b1;
      rx_sub_inc    = rx_sub_ff + 1'b1;
      tx_word       = '0;
      tx_pos        = '0;
      rx_got_inc    = rx_got_ff + 4'd1;
      rx_shift_t    = rx_shift_ff | (10'(rin) << rx_got_ff);
      rx_word       = rx_shift_t[7:0] & wmask;
      rx_bi         = (rx_shift_t == '0);
      rx_pe         = lcr_ff[3] && !rx_bi &&
                      (rx_shift_t[wl] != parity_bit(lcr_ff, rx_word));
      rx_fe         = !rx_shift_t[wl + {3'b0, lcr_ff[3]}];
      rx_pushed     = 1'b0;
      idle_base     = rx_idle_ff;

      if (accept) begin
         unique case (req_data.req_type)
            REQ_READ: begin
               unique case (req_data.reg_offset)
                  REG_RBR: begin
                     if (dlab) begin
                        rd = div_ff[7:0];
                     end else if (rx_count != '0) begin
                        rd         = rx_head[7:0];
                        rx_ctl.pop = 1'b1;
                        rx_idle_in = '0;
                        // the entry behind the head becomes visible
                        if (rx_count > CW'(1)) begin
                           lsf_in[3:1] = lsf_ff[3:1] | rx_nxt[10:8];
                        end
                        if (rx_head[10:8] != '0) begin
                           rx_err_cnt_in = rx_err_cnt_ff - 1'b1;
                        end
                     end
                  end
                  REG_IER: rd = dlab ? div_ff[15:8] : {4'b0, ier_ff};
                  REG_IIR: begin
                     rd = {fcr_ff[0], fcr_ff[0], 2'b00, iir_cur};
                     if (iir_cur == IIR_THRE) begin
                        thre_in = 1'b0;
                     end
                  end
                  REG_LCR: rd = lcr_ff;
                  REG_MCR: rd = {3'b0, mcr_ff};
                  REG_LSR: begin
                     rd     = lsr_cur;
                     lsf_in = '0;
                  end
                  REG_SCR: rd = scr_ff;
                  default: rd = '0;
               endcase
            end
            REQ_WRITE: begin
               unique case (req_data.reg_offset)
                  REG_RBR: begin
                     if (dlab) begin
                        div_in[7:0] = req_data.write_data;
                     end else begin
                        // a full holding fifo drops the byte
                        if (tx_count < depth_now) begin
                           tx_ctl.push = 1'b1;
                        end
                        thre_in = 1'b0;
                     end
                  end
                  REG_IER: begin
                     if (dlab) begin
                        div_in[15:8] = req_data.write_data;
                     end else begin
                        if (!ier_ff[1] && req_data.write_data[1] && (tx_count == '0)) begin
                           thre_in = 1'b1;
                        end
                        ier_in = req_data.write_data[3:0];
                     end
                  end
                  REG_IIR: begin
                     fcr_new  = req_data.write_data[0] ? (req_data.write_data & 8'hF9) : '0;
                     rx_clear = (fcr_new[0] ^ fcr_ff[0]) | req_data.write_data[1];
                     tx_clear = (fcr_new[0] ^ fcr_ff[0]) | req_data.write_data[2];
                     rx_ctl.clear = rx_clear;
                     tx_ctl.clear = tx_clear;
                     if (rx_clear) begin
                        rx_idle_in    = '0;
                        rx_err_cnt_in = '0;
                     end
                     fcr_in = fcr_new;
                  end
                  REG_LCR: lcr_in = req_data.write_data;
                  REG_MCR: mcr_in = req_data.write_data[4:0];
                  REG_SCR: scr_in = req_data.write_data;
                  default: ;
               endcase
            end
            REQ_TICK: begin
               if (div_ff != '0) begin
                  if (baud_inc < div_ff) begin
                     baud_in = baud_inc;
                  end else begin
                     baud_in = '0;

                     // transmit: finish the current bit, then load the next byte
                     if (tx_busy_ff) begin
                        if (tx_sub_inc >= SW'(OVERSAMPLE)) begin
                           tx_sub_in   = '0;
                           tx_shift_in = tx_shift_ff >> 1;
                           if (tx_left_ff != '0) begin
                              tx_left_in = tx_left_ff - 4'd1;
                           end
                           if (tx_left_in == '0) begin
                              tx_busy_in = 1'b0;
                           end
                        end else begin
                           tx_sub_in = tx_sub_inc;
                        end
                     end
                     if (!tx_busy_in && (tx_count != '0)) begin
                        tx_ctl.pop  = 1'b1;
                        tx_word     = tx_head & wmask;
                        tx_shift_in = {4'b0, tx_word, 1'b0};
                        tx_pos      = 4'd1 + wl;
                        if (lcr_ff[3]) begin
                           tx_shift_in = tx_shift_in |
                                         (13'(parity_bit(lcr_ff, tx_word)) << tx_pos);
                           tx_pos      = tx_pos + 4'd1;
                        end
                        tx_shift_in = tx_shift_in | (13'd3 << tx_pos);
                        tx_left_in  = tx_pos + (lcr_ff[2] ? 4'd2 : 4'd1);
                        tx_busy_in  = 1'b1;
                        tx_sub_in   = '0;
                        if (tx_count == CW'(1)) begin
                           thre_in = 1'b1;
                        end
                     end

                     // receive: start qualify at mid bit, then one sample per bit
                     unique case (rx_state_ff)
                        RX_IDLE: begin
                           if (!rin) begin
                              rx_state_in = RX_START;
                              rx_sub_in   = '0;
                           end
                        end
                        RX_START: begin
                           rx_sub_in = rx_sub_inc;
                           if (rx_sub_inc >= SW'(OVERSAMPLE / 2)) begin
                              if (rin) begin
                                 rx_state_in = RX_IDLE;
                              end else begin
                                 rx_state_in = RX_DATA;
                                 rx_sub_in   = '0;
                                 rx_got_in   = '0;
                                 rx_shift_in = '0;
                              end
                           end
                        end
                        RX_DATA: begin
                           if (rx_sub_inc >= SW'(OVERSAMPLE)) begin
                              rx_sub_in   = '0;
                              rx_shift_in = rx_shift_t;
                              rx_got_in   = rx_got_inc;
                              if (rx_got_inc >= wl + {3'b0, lcr_ff[3]} + 4'd1) begin
                                 if (rx_count >= depth_now) begin
                                    // overrun drops the new character
                                    lsf_in[0] = 1'b1;
                                 end else begin
                                    rx_ctl.push = 1'b1;
                                    rx_wdata    = {rx_bi, rx_fe, rx_pe, rx_word};
                                    rx_pushed   = 1'b1;
                                    if (rx_count == '0) begin
                                       lsf_in[3:1] = lsf_ff[3:1] | {rx_bi, rx_fe, rx_pe};
                                    end
                                    if (rx_bi || rx_fe || rx_pe) begin
                                       rx_err_cnt_in = rx_err_cnt_ff + 1'b1;
                                    end
                                 end
                                 rx_state_in = rx_bi ? RX_BREAK : RX_IDLE;
                              end
                           end else begin
                              rx_sub_in = rx_sub_inc;
                           end
                        end
                        RX_BREAK: begin
                           // wait for the line to return high
                           if (rin) begin
                              rx_state_in = RX_IDLE;
                           end
                        end
                        default: rx_state_in = RX_IDLE;
                     endcase

                     // idle time counts only while fifo mode holds data
                     idle_base = rx_pushed ? 16'd0 : rx_idle_ff;
                     if (fcr_ff[0] && (rx_count_next != '0)) begin
                        rx_idle_in = (idle_base == 16'hFFFF) ? idle_base : idle_base + 16'd1;
                     end else begin
                        rx_idle_in = '0;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // result seen after the transaction took effect
   assign iir_next = iir_code(ier_in, lsf_in, rx_count_next >= rx_trigger(fcr_in),
                              timeout(fcr_in, lcr_in, rx_count_next, rx_idle_in), thre_in);

   always_comb begin
      rsp_in.read_data = rd;
      rsp_in.tx_line   = mcr_in[4] ? 1'b1 :
                         (lcr_in[6] ? 1'b0 : (tx_busy_in ? tx_shift_in[0] : 1'b1));
      rsp_in.irq       = !iir_next[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lcr_ff        <= '0;
         div_ff        <= '0;
         ier_ff        <= '0;
         fcr_ff        <= '0;
         mcr_ff        <= '0;
         scr_ff        <= '0;
         baud_ff       <= '0;
         tx_busy_ff    <= 1'b0;
         tx_shift_ff   <= '0;
         tx_left_ff    <= '0;
         tx_sub_ff     <= '0;
         rx_state_ff   <= RX_IDLE;
         rx_sub_ff     <= '0;
         rx_got_ff     <= '0;
         rx_shift_ff   <= '0;
         lsf_ff        <= '0;
         thre_ff       <= 1'b0;
         rx_idle_ff    <= '0;
         rx_err_cnt_ff <= '0;
      end else begin
         lcr_ff        <= lcr_in;
         div_ff        <= div_in;
         ier_ff        <= ier_in;
         fcr_ff        <= fcr_in;
         mcr_ff        <= mcr_in;
         scr_ff        <= scr_in;
         baud_ff       <= baud_in;
         tx_busy_ff    <= tx_busy_in;
         tx_shift_ff   <= tx_shift_in;
         tx_left_ff    <= tx_left_in;
         tx_sub_ff     <= tx_sub_in;
         rx_state_ff   <= rx_state_in;
         rx_sub_ff     <= rx_sub_in;
         rx_got_ff     <= rx_got_in;
         rx_shift_ff   <= rx_shift_in;
         lsf_ff        <= lsf_in;
         thre_ff       <= thre_in;
         rx_idle_ff    <= rx_idle_in;
         rx_err_cnt_ff <= rx_err_cnt_in;
      end
   end

   // ---------------------------------------------------------------------
   // fifos and output buffer
   // ---------------------------------------------------------------------
   u16550_fifo #(
      .WIDTH (8),
      .DEPTH (FIFO_DEPTH)
   ) u_tx_fifo (
      .clock      (clock),
      .reset      (reset),
      .ctl        (tx_ctl),
      .wr_data    (tx_wdata),
      .count      (tx_count),
      .count_next (tx_count_next),
      .head       (tx_head),
      .nxt        (tx_nxt)
   );

   u16550_fifo #(
      .WIDTH (11),
      .DEPTH (FIFO_DEPTH)
   ) u_rx_fifo (
      .clock      (clock),
      .reset      (reset),
      .ctl        (rx_ctl),
      .wr_data    (rx_wdata),
      .count      (rx_count),
      .count_next (rx_count_next),
      .head       (rx_head),
      .nxt        (rx_nxt)
   );

   u16550_skid u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_stall  (req_stall),
      .in_data   (rsp_in),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   // ---------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------
   a_tx_busy_has_bits: assert property (@(posedge clock) disable iff (reset)
      tx_busy_ff |-> (tx_left_ff != '0))
      else $error("transmitter busy with no bits left");

   a_err_count_bound: assert property (@(posedge clock) disable iff (reset)
      rx_err_cnt_ff <= rx_count)
      else $error("receive error count exceeds held entries");

   a_tx_pop_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      tx_ctl.pop |-> accept && (req_data.req_type == REQ_TICK) && !tx_busy_in == 1'b0)
      else $error("transmit fifo popped outside a baud pulse load");

endmodule
